// ----- src/vscl_pkg.sv -----
// Package: shared constants, word types and table write bundle for the voxel slice locator.
`default_nettype none
package vscl_pkg;

  // Geometry
  localparam int MAX_SLICES  = 16;
  localparam int CUBE_SIZE   = 128;
  localparam int COORD_BITS  = 24;
  localparam int CUBE_SHIFT  = $clog2(CUBE_SIZE);
  localparam int CELL_BITS   = COORD_BITS - CUBE_SHIFT;
  localparam int IDX_BITS    = 17;
  localparam int SLICE_BITS  = 4;
  localparam int COUNT_BITS  = 5;

  // Configuration port
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_EDGE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_EDGE  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BACK_EDGE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRONT_EDGE  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLICE_COUNT = 3'd4;

  // Input word function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOCATE = 1'b1;

  typedef struct packed {
    logic                          func;
    logic [SLICE_BITS-1:0]         slice_number;
    logic signed [COORD_BITS-1:0]  slice_top;
    logic signed [COORD_BITS-1:0]  slice_bottom;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic signed [COORD_BITS-1:0]  point_z;
  } in_word_t;

  typedef struct packed {
    logic                          inside_res;
    logic [IDX_BITS-1:0]           index_x;
    logic [SLICE_BITS-1:0]         index_y;
    logic [IDX_BITS-1:0]           index_z;
    logic signed [COORD_BITS-1:0]  cube_left;
    logic signed [COORD_BITS-1:0]  cube_right;
    logic signed [COORD_BITS-1:0]  cube_back;
    logic signed [COORD_BITS-1:0]  cube_front;
    logic signed [COORD_BITS-1:0]  cube_bottom;
    logic signed [COORD_BITS-1:0]  cube_top;
  } out_word_t;

  // Slice table write bundle
  typedef struct packed {
    logic                          en;
    logic [SLICE_BITS-1:0]         addr;
    logic signed [COORD_BITS-1:0]  top;
    logic signed [COORD_BITS-1:0]  bottom;
  } tbl_wr_t;

endpackage
`default_nettype wire

// ----- src/vscl_slice_table.sv -----
// Slice limit table: per-entry height compares and one indexed read of the limits.
`default_nettype none
module vscl_slice_table
  import vscl_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire tbl_wr_t                      wr_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  output logic [MAX_SLICES-1:0]             above_top_o,
  output logic                              below_floor_o,
  input  wire logic [SLICE_BITS-1:0]        rd_addr_i,
  output logic signed [COORD_BITS-1:0]      rd_top_o,
  output logic signed [COORD_BITS-1:0]      rd_bottom_o
);

  logic signed [COORD_BITS-1:0] top_q    [MAX_SLICES];
  logic signed [COORD_BITS-1:0] bottom_q [MAX_SLICES];

  // Entry write, no reset: entries are undefined until loaded
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      top_q[wr_i.addr]    <= wr_i.top;
      bottom_q[wr_i.addr] <= wr_i.bottom;
    end
  end

  // Point above each slice top, in parallel
  always_comb begin
    for (int i = 0; i < MAX_SLICES; i++) begin
      above_top_o[i] = point_y_i > top_q[i];
    end
  end

  // Absolute bottom is slice 0
  assign below_floor_o = point_y_i < bottom_q[0];

  // Limits of the chosen slice
  assign rd_top_o    = top_q[rd_addr_i];
  assign rd_bottom_o = bottom_q[rd_addr_i];

endmodule
`default_nettype wire

// ----- src/voxel_slice_cell_locator.sv -----
// Top level: three-stage voxel slice cell locator with config registers and slice table.
//
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+-----------------------------------
//  in       | input     | in_valid_i/in_stall_o   | in_word_t (load or locate)
//  out      | output    | out_valid_o/out_stall_i | out_word_t (one per locate)
//  cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle enters while in_stall_o is low; the pipeline is input register,
// compare stage, result register, and a locate result is offered from the result register.
// Loads write the table when they leave the input register and give no result.
// Reset clears valids and edge registers and sets the slice count to 1; table entries are undefined until loaded.
// A stalled output holds its word; stall backs up stage by stage to in_stall_o.
`default_nettype none
module voxel_slice_cell_locator
  import vscl_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire in_word_t                in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output out_word_t                    out_data_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [COORD_BITS-1:0]   cfg_data_i
);

  // Config registers
  logic signed [COORD_BITS-1:0] left_q, right_q, back_q, front_q;
  logic [COUNT_BITS-1:0]        count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      back_q  <= '0;
      front_q <= '0;
      count_q <= COUNT_BITS'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LEFT_EDGE:   left_q  <= cfg_data_i;
        REG_RIGHT_EDGE:  right_q <= cfg_data_i;
        REG_BACK_EDGE:   back_q  <= cfg_data_i;
        REG_FRONT_EDGE:  front_q <= cfg_data_i;
        REG_SLICE_COUNT: count_q <= cfg_data_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_en, s2_en, out_en;

  assign out_en     = !out_valid_q || !out_stall_i;
  assign s2_en      = !s2_valid_q || out_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;

  // Stage 1: input register
  in_word_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // Slice table; a load writes as it leaves stage 1
  tbl_wr_t                      tbl_wr;
  logic [MAX_SLICES-1:0]        above_top;
  logic                         below_floor;
  logic [SLICE_BITS-1:0]        slice_sel;
  logic signed [COORD_BITS-1:0] sel_top, sel_bottom;

  assign tbl_wr.en     = s1_valid_q && (s1_q.func == FUNC_LOAD) && s2_en;
  assign tbl_wr.addr   = s1_q.slice_number;
  assign tbl_wr.top    = s1_q.slice_top;
  assign tbl_wr.bottom = s1_q.slice_bottom;

  vscl_slice_table u_table (
    .clk_i         (clk_i),
    .wr_i          (tbl_wr),
    .point_y_i     (s1_q.point_y),
    .above_top_o   (above_top),
    .below_floor_o (below_floor),
    .rd_addr_i     (slice_sel),
    .rd_top_o      (sel_top),
    .rd_bottom_o   (sel_bottom)
  );

  // Stage 1 logic: edge checks and floor cells
  logic xz_out;
  assign xz_out = (s1_q.point_x < left_q) || (s1_q.point_x > right_q) ||
                  (s1_q.point_z < back_q) || (s1_q.point_z > front_q);

  // Stage 2 registers
  logic                        s2_out_q;
  logic [MAX_SLICES-1:0]       s2_above_q;
  logic signed [CELL_BITS-1:0] s2_ix_q, s2_iz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q && (s1_q.func == FUNC_LOCATE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_out_q   <= xz_out || below_floor;
      s2_above_q <= above_top;
      s2_ix_q    <= s1_q.point_x[COORD_BITS-1:CUBE_SHIFT];
      s2_iz_q    <= s1_q.point_z[COORD_BITS-1:CUBE_SHIFT];
    end
  end

  // Last slice in use, count clamped to 1..MAX_SLICES
  logic [SLICE_BITS-1:0] last_slice;
  always_comb begin
    if (count_q == '0) begin
      last_slice = '0;
    end else if (count_q > COUNT_BITS'(MAX_SLICES)) begin
      last_slice = SLICE_BITS'(MAX_SLICES - 1);
    end else begin
      last_slice = SLICE_BITS'(count_q - COUNT_BITS'(1));
    end
  end

  // First slice whose top is not below the point, else the last one
  always_comb begin
    slice_sel = last_slice;
    for (int i = MAX_SLICES - 1; i >= 0; i--) begin
      if ((SLICE_BITS'(i) < last_slice) && !s2_above_q[i]) begin
        slice_sel = SLICE_BITS'(i);
      end
    end
  end

  // Edge cells, truncated toward zero
  logic signed [COORD_BITS-1:0] left_adj, back_adj;
  logic signed [CELL_BITS-1:0]  left_cell, back_cell;

  assign left_adj  = left_q + (left_q[COORD_BITS-1] ? COORD_BITS'(CUBE_SIZE - 1) : '0);
  assign back_adj  = back_q + (back_q[COORD_BITS-1] ? COORD_BITS'(CUBE_SIZE - 1) : '0);
  assign left_cell = left_adj[COORD_BITS-1:CUBE_SHIFT];
  assign back_cell = back_adj[COORD_BITS-1:CUBE_SHIFT];

  // Stage 2 logic: result word
  logic      outside;
  out_word_t res;
  logic [CELL_BITS-1:0] dx, dz;

  assign outside = s2_out_q || s2_above_q[last_slice];
  assign dx      = s2_ix_q - left_cell;
  assign dz      = s2_iz_q - back_cell;

  always_comb begin
    res = '0;
    if (!outside) begin
      res.inside_res  = 1'b1;
      res.index_x     = IDX_BITS'(dx);
      res.index_y     = slice_sel;
      res.index_z     = IDX_BITS'(dz);
      res.cube_left   = {s2_ix_q, {CUBE_SHIFT{1'b0}}};
      res.cube_right  = {s2_ix_q, {CUBE_SHIFT{1'b1}}};
      res.cube_back   = {s2_iz_q, {CUBE_SHIFT{1'b0}}};
      res.cube_front  = {s2_iz_q, {CUBE_SHIFT{1'b1}}};
      res.cube_bottom = sel_bottom;
      res.cube_top    = sel_top;
    end
  end

  // Stage 3: output register
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.inside_res |-> out_data_o == '0)
    else $error("outside result carries nonzero fields");

  a_cube_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.inside_res |->
      out_data_o.cube_right == (out_data_o.cube_left | COORD_BITS'(CUBE_SIZE - 1)))
    else $error("cube right side does not match cube left side");

  a_no_write_under_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr.en |-> !(s2_valid_q && !out_en))
    else $error("table written while an older locate is held in stage 2");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench for the voxel slice cell locator: random and directed words against a predictor.
`default_nettype none
module testbench;
  import vscl_pkg::*;

  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     HOLD_CYCLES  = 200;
  localparam int     PHASE_ITEMS  = 55;
  localparam int     PHASE_COUNT  = 8;
  localparam longint COORD_MIN    = -(longint'(1) << (COORD_BITS - 1));
  localparam longint COORD_MAX    = (longint'(1) << (COORD_BITS - 1)) - 1;
  // first index past the register list; writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = REG_SLICE_COUNT + 1'b1;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  // Predictor of the located cell plus the queue of cells still due
  class locator_scoreboard;
    longint                left_e, right_e, back_e, front_e;
    logic [COUNT_BITS-1:0] slice_cnt;
    longint                top_tbl [MAX_SLICES];
    longint                bot_tbl [MAX_SLICES];
    out_word_t             cells_due [$];
    int                    fails;
    int                    results_seen;

    function new();
      left_e = 0;
      right_e = 0;
      back_e = 0;
      front_e = 0;
      slice_cnt = 1;
      fails = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return cells_due.size();
    endfunction

    function void note_config(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] data);
      case (idx)
        REG_LEFT_EDGE:   left_e = longint'($signed(data));
        REG_RIGHT_EDGE:  right_e = longint'($signed(data));
        REG_BACK_EDGE:   back_e = longint'($signed(data));
        REG_FRONT_EDGE:  front_e = longint'($signed(data));
        REG_SLICE_COUNT: slice_cnt = data[COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    // exact floor division by the cube size
    function longint cube_floor(longint a);
      if (a >= 0) return a / CUBE_SIZE;
      return -((-a - 1) / CUBE_SIZE) - 1;
    endfunction

    function out_word_t locate_cell(in_word_t w);
      out_word_t r;
      longint    x, y, z, cx, cz, v;
      int        n, s;
      r = '0;
      x = longint'($signed(w.point_x));
      y = longint'($signed(w.point_y));
      z = longint'($signed(w.point_z));
      // zero slices acts as one, anything past the table as the full table
      n = (slice_cnt == 0) ? 1 : (slice_cnt > MAX_SLICES) ? MAX_SLICES : int'(slice_cnt);
      if (x < left_e || x > right_e || z < back_e || z > front_e ||
          y < bot_tbl[0] || y > top_tbl[n - 1])
        return r;
      cx = cube_floor(x);
      cz = cube_floor(z);
      // first slice whose top is not below the point, else the last in use
      s = 0;
      while (s < n - 1 && y > top_tbl[s])
        s++;
      r.inside_res = 1'b1;
      // minimum index truncates toward zero, so the index may wrap
      v = cx - left_e / CUBE_SIZE;
      r.index_x = v[IDX_BITS-1:0];
      r.index_y = s[SLICE_BITS-1:0];
      v = cz - back_e / CUBE_SIZE;
      r.index_z = v[IDX_BITS-1:0];
      v = cx * CUBE_SIZE;
      r.cube_left = v[COORD_BITS-1:0];
      v = v + CUBE_SIZE - 1;
      r.cube_right = v[COORD_BITS-1:0];
      v = cz * CUBE_SIZE;
      r.cube_back = v[COORD_BITS-1:0];
      v = v + CUBE_SIZE - 1;
      r.cube_front = v[COORD_BITS-1:0];
      r.cube_bottom = bot_tbl[s][COORD_BITS-1:0];
      r.cube_top = top_tbl[s][COORD_BITS-1:0];
      return r;
    endfunction

    function void note_input(in_word_t w);
      if (w.func == FUNC_LOAD) begin
        if (w.slice_number < MAX_SLICES) begin
          top_tbl[w.slice_number] = longint'($signed(w.slice_top));
          bot_tbl[w.slice_number] = longint'($signed(w.slice_bottom));
        end
      end else begin
        cells_due.push_back(locate_cell(w));
      end
    endfunction

    task report(string msg);
      fails++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      string     diffs;
      results_seen++;
      if (cells_due.size() == 0) begin
        report($sformatf("result %0d arrived with no word due", results_seen));
        return;
      end
      want = cells_due.pop_front();
      diffs = "";
      if (got.inside_res !== want.inside_res)
        diffs = {diffs, $sformatf(" inside_res %0h/%0h", got.inside_res, want.inside_res)};
      if (got.index_x !== want.index_x)
        diffs = {diffs, $sformatf(" index_x %0h/%0h", got.index_x, want.index_x)};
      if (got.index_y !== want.index_y)
        diffs = {diffs, $sformatf(" index_y %0h/%0h", got.index_y, want.index_y)};
      if (got.index_z !== want.index_z)
        diffs = {diffs, $sformatf(" index_z %0h/%0h", got.index_z, want.index_z)};
      if (got.cube_left !== want.cube_left)
        diffs = {diffs, $sformatf(" cube_left %0h/%0h", got.cube_left, want.cube_left)};
      if (got.cube_right !== want.cube_right)
        diffs = {diffs, $sformatf(" cube_right %0h/%0h", got.cube_right, want.cube_right)};
      if (got.cube_back !== want.cube_back)
        diffs = {diffs, $sformatf(" cube_back %0h/%0h", got.cube_back, want.cube_back)};
      if (got.cube_front !== want.cube_front)
        diffs = {diffs, $sformatf(" cube_front %0h/%0h", got.cube_front, want.cube_front)};
      if (got.cube_bottom !== want.cube_bottom)
        diffs = {diffs, $sformatf(" cube_bottom %0h/%0h", got.cube_bottom, want.cube_bottom)};
      if (got.cube_top !== want.cube_top)
        diffs = {diffs, $sformatf(" cube_top %0h/%0h", got.cube_top, want.cube_top)};
      if (diffs != "")
        report($sformatf("result %0d got/want:%s", results_seen, diffs));
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  in_word_t                in_data = '0;
  logic                    out_stall = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0]   cfg_data = '0;
  logic                    in_stall;
  logic                    out_valid;
  logic                    cfg_ready;
  out_word_t               out_data;

  locator_scoreboard sb;

  // generator's own view of the geometry, kept in stimulus order
  longint gen_left, gen_right, gen_back, gen_front;
  int     gen_slices = 1;
  longint lay_top [MAX_SLICES];
  longint lay_bot [MAX_SLICES];
  int     burst_left = 0;
  bit     no_gaps = 1'b0;
  logic   hold_req = 1'b0;
  int     cycles = 0;

  voxel_slice_cell_locator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Monitor: register writes, accepted words and results, in that order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready)
        sb.note_config(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        sb.note_input(in_data);
      if (out_valid && !out_stall)
        sb.check_result(out_data);
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  initial begin : rx_pattern
    int       seg_left;
    rx_mode_e mode;
    seg_left = 0;
    mode = RX_FLOW;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        seg_left = 0;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(4, 40);
        end
        seg_left--;
        case (mode)
          RX_FLOW:   out_stall <= 1'b0;
          RX_LIGHT:  out_stall <= ($urandom_range(0, 99) < 30);
          RX_HEAVY:  out_stall <= ($urandom_range(0, 99) < 70);
          default:   out_stall <= ~out_stall;
        endcase
      end
    end
  end

  function automatic longint clamp_coord(longint v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic longint rand_coord();
    logic [COORD_BITS-1:0] r;
    r = COORD_BITS'($urandom);
    return longint'($signed(r));
  endfunction

  // mostly inside [lo, hi], some right on or just past its ends, some anywhere
  function automatic longint pick(longint lo, longint hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (hi < lo || roll < 8)
      return rand_coord();
    if (roll < 18) begin
      case ($urandom_range(0, 3))
        0:       return lo;
        1:       return hi;
        2:       return clamp_coord(lo - 1);
        default: return clamp_coord(hi + 1);
      endcase
    end
    return lo + $urandom_range(0, hi - lo);
  endfunction

  // Offer one word, in bursts with random gaps, and wait until it is taken
  task automatic offer(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_load(int num, longint top, longint bot);
    in_word_t w;
    w.func = FUNC_LOAD;
    w.slice_number = num[SLICE_BITS-1:0];
    w.slice_top = top[COORD_BITS-1:0];
    w.slice_bottom = bot[COORD_BITS-1:0];
    w.point_x = COORD_BITS'($urandom);
    w.point_y = COORD_BITS'($urandom);
    w.point_z = COORD_BITS'($urandom);
    lay_top[num] = top;
    lay_bot[num] = bot;
    offer(w);
  endtask

  task automatic send_locate(longint x, longint y, longint z);
    in_word_t w;
    w.func = FUNC_LOCATE;
    w.slice_number = SLICE_BITS'($urandom);
    w.slice_top = COORD_BITS'($urandom);
    w.slice_bottom = COORD_BITS'($urandom);
    w.point_x = x[COORD_BITS-1:0];
    w.point_y = y[COORD_BITS-1:0];
    w.point_z = z[COORD_BITS-1:0];
    offer(w);
  endtask

  // Sender pauses until every cell due has come out, then lets loads settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    // let the monitor log the word taken at the last edge
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Write all registers plus one write to an index past the list
  task automatic configure(longint le, longint re, longint be, longint fe,
                           logic [COORD_BITS-1:0] cnt_word);
    logic [CFG_IDX_BITS-1:0] idx [6];
    logic [COORD_BITS-1:0]   dat [6];
    logic [COUNT_BITS-1:0]   cnt;
    idx[0] = REG_LEFT_EDGE;   dat[0] = le[COORD_BITS-1:0];
    idx[1] = REG_RIGHT_EDGE;  dat[1] = re[COORD_BITS-1:0];
    idx[2] = REG_BACK_EDGE;   dat[2] = be[COORD_BITS-1:0];
    idx[3] = REG_FRONT_EDGE;  dat[3] = fe[COORD_BITS-1:0];
    idx[4] = REG_SLICE_COUNT; dat[4] = cnt_word;
    idx[5] = CFG_IDX_BITS'(REG_UNUSED + $urandom_range(0, 2));
    dat[5] = COORD_BITS'($urandom);
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= dat[i];
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    gen_left = le;
    gen_right = re;
    gen_back = be;
    gen_front = fe;
    cnt = cnt_word[COUNT_BITS-1:0];
    gen_slices = (cnt == 0) ? 1 : (cnt > MAX_SLICES) ? MAX_SLICES : int'(cnt);
  endtask

  task automatic rand_span(output longint lo, output longint hi);
    longint span;
    lo = COORD_MIN + $urandom_range(0, (1 << COORD_BITS) - 1);
    case ($urandom_range(0, 2))
      0:       span = $urandom_range(0, 300);
      1:       span = $urandom_range(0, 20000);
      default: span = $urandom_range(0, 1 << 22);
    endcase
    hi = clamp_coord(lo + span);
  endtask

  // Load an ascending stack of slices, sometimes with holes between them
  task automatic fill_layout(bit extreme);
    longint span_max, cur, top;
    case ($urandom_range(0, 2))
      0:       span_max = 16;
      1:       span_max = 3000;
      default: span_max = 400000;
    endcase
    cur = COORD_MIN + $urandom_range(0, (1 << COORD_BITS) - 1 - 32 * span_max);
    for (int i = 0; i < MAX_SLICES; i++) begin
      top = cur + $urandom_range(1, span_max) - 1;
      if (extreme && i == 0)
        send_load(i, top, COORD_MIN);
      else if (extreme && i == MAX_SLICES - 1)
        send_load(i, COORD_MAX, cur);
      else
        send_load(i, top, cur);
      cur = top + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, span_max) : 0);
    end
  endtask

  // Mostly well-aimed locates, a few rewrites and a few noise loads
  task automatic random_item();
    int roll, k;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      k = $urandom_range(0, MAX_SLICES - 1);
      send_load(k, lay_top[k], lay_bot[k]);
    end else if (roll < 10) begin
      send_load($urandom_range(0, MAX_SLICES - 1), rand_coord(), rand_coord());
    end else if (roll < 25) begin
      // right on a slice top or just above it
      k = $urandom_range(0, gen_slices - 1);
      send_locate(pick(gen_left, gen_right), clamp_coord(lay_top[k] + $urandom_range(0, 1)),
                  pick(gen_back, gen_front));
    end else begin
      send_locate(pick(gen_left, gen_right), pick(lay_bot[0], lay_top[gen_slices - 1]),
                  pick(gen_back, gen_front));
    end
  endtask

  initial begin : stimulus
    longint                le, re, be, fe;
    logic [COORD_BITS-1:0] cw;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ascending table of 100-unit slices from -800 up to 799
    for (int i = 0; i < MAX_SLICES; i++)
      send_load(i, -701 + 100 * i, -800 + 100 * i);
    // reset geometry: one column at the origin, one slice
    send_locate(0, -750, 0);
    send_locate(1, -750, 0);

    // edges off the cube grid in X, full range in Z, full table
    wait_idle();
    configure(-1000, 1000, COORD_MIN, COORD_MAX, COORD_BITS'(MAX_SLICES));
    send_locate(-1000, -800, COORD_MIN);
    send_locate(1000, 799, COORD_MAX);
    send_locate(-1001, 0, 0);
    send_locate(1001, 0, 0);
    send_locate(0, -801, 0);
    send_locate(0, 800, 0);
    send_locate(-1, -701, 127);
    send_locate(-128, -700, -129);

    // slice count past the table, narrow Z
    wait_idle();
    configure(-1000, 1000, -50, 50, COORD_BITS'({COUNT_BITS{1'b1}}));
    send_locate(0, 0, -51);
    send_locate(0, 0, 51);
    send_locate(0, 0, 50);

    // tops out of order: the point runs through to the last slice in use
    send_load(1, -2000, -700);
    wait_idle();
    configure(-1000, 1000, -50, 50, COORD_BITS'(3));
    send_locate(5, -600, 5);

    // random phases, each with its own geometry and table
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_idle();
      rand_span(le, re);
      rand_span(be, fe);
      cw = COORD_BITS'($urandom);
      cw[COUNT_BITS-1:0] = COUNT_BITS'($urandom_range(1, MAX_SLICES));
      case (ph)
        0: begin
          le = COORD_MIN;
          re = COORD_MAX;
          be = COORD_MIN;
          fe = COORD_MAX;
          cw[COUNT_BITS-1:0] = COUNT_BITS'(MAX_SLICES);
        end
        1: cw[COUNT_BITS-1:0] = '0;
        2: cw[COUNT_BITS-1:0] = '1;
        4: begin
          le = 0;
          re = 0;
          be = 0;
          fe = 0;
        end
        default: ;
      endcase
      configure(le, re, be, fe, cw);
      fill_layout(ph == 0);
      no_gaps = (ph == 3 || ph == 5);
      if (ph == 3)
        hold_req <= 1'b1;
      repeat (PHASE_ITEMS) random_item();
    end

    wait_idle();
    if (sb.fails == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
